>>> sv/aptv_pkg.sv
// Package: constants, status codes, function codes and sequencer states for the stamp validator.
package aptv_pkg;

   localparam int unsigned HistoryNeeded = 5;
   localparam int unsigned HistW = $clog2(HistoryNeeded + 1);

   localparam logic [63:0] NsScale    = 64'd10000000;
   localparam logic [18:0] RateDiv    = 19'd100;
   localparam logic [63:0] BoundNs    = 64'd10000000;
   localparam logic [63:0] GapBoundNs = 64'd3000000;
   localparam logic [18:0] RateReset  = 19'd48000;

   typedef enum logic [1:0] {
      STATUS_SUCCESS = 2'd0,
      STATUS_FAILED  = 2'd1,
      STATUS_MODIFY  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FUNC_UPDATE = 2'd0,
      FUNC_RESET  = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDIV,
      ST_MUL,
      ST_DIV,
      ST_PRED,
      ST_GAP_START,
      ST_GAP_DIV,
      ST_GAP_END,
      ST_QUERY_END,
      ST_OUT
   } state_type;

endpackage

>>> sv/audio_position_timestamp_validator.sv
// Top level: anchor/history stamp validator with a shared serial multiply/divide unit.
//
//  channel | ports                                     | direction
//  req     | req_valid/req_ready, func, frame, nano_time | in
//  rsp     | rsp_valid/rsp_ready, status, pos_time, anchors | out
//  csr     | csr_we, csr_wdata (sample_rate)           | in
//
// Reset-anchor and unused words answer on the next cycle. Others step through rate/100
// (reciprocal multiply), the serial multiply by 1e7 and the serial divide; a query then
// forms its position time, an update checks the prediction, and the gap check adds its
// own multiply and divide before the result is registered.
// Synchronous active-high reset clears anchors and history count, and sets sample_rate to 48000.
// A result waits in the output register; the next word is taken once it leaves.
module audio_position_timestamp_validator
   import aptv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_frame,
   input  logic signed [63:0] req_nano_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic signed [63:0] rsp_pos_time,
   output logic [63:0] rsp_anchor_frame_out,
   output logic signed [63:0] rsp_anchor_time_out,
   input  logic        csr_we,
   input  logic [18:0] csr_wdata
);

   state_type state_ff, state_in;
   logic [18:0] rate_ff, rate_in;
   logic [63:0] anc_f_ff, anc_f_in, anc_t_ff, anc_t_in;
   logic [HistW-1:0] hcnt_ff, hcnt_in;
   logic bad_ff, bad_in;
   logic [63:0] hf_ff, hf_in, ht_ff, ht_in;
   logic [1:0] func_ff, func_in;
   logic [63:0] fr_ff, fr_in, nt_ff, nt_in;
   // shared serial unit: acc is remainder/product, q is quotient/multiplier
   logic [63:0] acc_ff, acc_in, q_ff, q_in;
   logic [18:0] dv_ff, dv_in;
   logic [6:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic qsub_ff, qsub_in;
   logic [63:0] pred_ff, pred_in;
   logic rv_ff, rv_in;
   logic [1:0] st_ff, st_in;
   logic [63:0] pt_ff, pt_in, of_ff, of_in, ot_ff, ot_in;

   logic [64:0] trial;
   logic [63:0] term, pdelta, err, lo, hi, gdelta;
   logic near, gapok, fullnow;
   logic [HistW-1:0] hnext;
   logic [38:0] rprod;
   logic [18:0] rquot;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rate_ff  <= RateReset;
         anc_f_ff <= '0;
         anc_t_ff <= '0;
         hcnt_ff  <= '0;
         bad_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rate_ff  <= rate_in;
         anc_f_ff <= anc_f_in;
         anc_t_ff <= anc_t_in;
         hcnt_ff  <= hcnt_in;
         bad_ff   <= bad_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      hf_ff <= hf_in;  ht_ff <= ht_in;
      func_ff <= func_in; fr_ff <= fr_in; nt_ff <= nt_in;
      acc_ff <= acc_in; q_ff <= q_in; dv_ff <= dv_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; qsub_ff <= qsub_in; pred_ff <= pred_in;
      st_ff <= st_in; pt_ff <= pt_in; of_ff <= of_in; ot_ff <= ot_in;
   end

   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_pos_time = pt_ff;
   assign rsp_anchor_frame_out = of_ff;
   assign rsp_anchor_time_out = ot_ff;

   always_comb begin
      trial  = {acc_ff, q_ff[63]} - {46'd0, dv_ff};
      term   = (dv_ff == '0) ? 64'd0 : (neg_ff ? 64'd0 - q_ff : q_ff);
      pdelta = fr_ff - anc_f_ff;
      lo     = pred_ff - BoundNs;
      hi     = pred_ff + BoundNs;
      near   = ((fr_ff == anc_f_ff) && (nt_ff == anc_t_ff)) ||
               ($signed(nt_ff) <= $signed(hi) && $signed(nt_ff) >= $signed(lo));
      gdelta = fr_ff - hf_ff;
      err    = nt_ff - ht_ff - term;
      gapok  = (hf_ff < fr_ff) && ($signed(err) < $signed(GapBoundNs)) &&
               ($signed(err) > -$signed(GapBoundNs));
      hnext  = (hcnt_ff < HistW'(HistoryNeeded)) ? hcnt_ff + HistW'(1) : hcnt_ff;
      fullnow = (hnext == HistW'(HistoryNeeded));
      // rate / 100 as rate * ceil(2^26 / 100) >> 26, exact over 19 bits
      rprod  = {20'd0, rate_ff} * 39'd671089;
      rquot  = {6'd0, rprod[38:26]};
   end

   always_comb begin
      state_in = state_ff; rate_in = rate_ff;
      anc_f_in = anc_f_ff; anc_t_in = anc_t_ff;
      hcnt_in = hcnt_ff; bad_in = bad_ff; hf_in = hf_ff; ht_in = ht_ff;
      func_in = func_ff; fr_in = fr_ff; nt_in = nt_ff;
      acc_in = acc_ff; q_in = q_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; qsub_in = qsub_ff; pred_in = pred_ff;
      rv_in = rv_ff; st_in = st_ff; pt_in = pt_ff; of_in = of_ff; ot_in = ot_ff;
      if (csr_we) rate_in = csr_wdata;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               func_in = req_func; fr_in = req_frame; nt_in = req_nano_time;
               case (func_type'(req_func))
                  FUNC_RESET: begin
                     anc_f_in = req_frame; anc_t_in = req_nano_time;
                     hcnt_in = '0; bad_in = 1'b0;
                     st_in = STATUS_SUCCESS; pt_in = '0;
                     of_in = req_frame; ot_in = req_nano_time;
                     rv_in = 1'b1;
                  end
                  FUNC_NONE: begin
                     st_in = STATUS_SUCCESS; pt_in = '0;
                     of_in = anc_f_ff; ot_in = anc_t_ff; rv_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_RDIV;
                  end
               endcase
            end
         end
         ST_RDIV: begin
            dv_in = rquot;
            qsub_in = (func_ff == FUNC_QUERY) && (fr_ff < anc_f_ff);
            q_in = ((func_ff == FUNC_QUERY) && (fr_ff < anc_f_ff)) ?
                   anc_f_ff - fr_ff : pdelta;
            acc_in = '0; cnt_in = 7'd64; state_in = ST_MUL;
         end
         ST_MUL: begin
            // shift-add multiply by 1e7, low 64 bits
            acc_in = {acc_ff[62:0], 1'b0} + (q_ff[63] ? NsScale : 64'd0);
            q_in = {q_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               neg_in = acc_in[63];
               q_in = acc_in[63] ? 64'd0 - acc_in : acc_in;
               acc_in = '0; cnt_in = 7'd64; state_in = ST_DIV;
            end
         end
         ST_DIV, ST_GAP_DIV: begin
            if (!trial[64]) begin
               acc_in = trial[63:0]; q_in = {q_ff[62:0], 1'b1};
            end else begin
               acc_in = {acc_ff[62:0], q_ff[63]}; q_in = {q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1)
               state_in = (state_ff == ST_GAP_DIV) ? ST_GAP_END :
                          (func_ff == FUNC_QUERY) ? ST_QUERY_END : ST_PRED;
         end
         ST_QUERY_END: begin
            pt_in = qsub_ff ? anc_t_ff - term : anc_t_ff + term;
            st_in = STATUS_SUCCESS; of_in = anc_f_ff; ot_in = anc_t_ff;
            state_in = ST_OUT;
         end
         ST_PRED: begin
            pred_in = anc_t_ff + term;
            state_in = ST_GAP_START;
         end
         ST_GAP_START: begin
            if (near) begin
               anc_f_in = fr_ff; anc_t_in = nt_ff; hcnt_in = '0; bad_in = 1'b0;
               st_in = STATUS_SUCCESS; pt_in = '0; of_in = fr_ff; ot_in = nt_ff;
               state_in = ST_OUT;
            end else if (hcnt_ff == '0) begin
               state_in = ST_GAP_END;
               neg_in = 1'b0; q_in = '0; dv_in = '0;
            end else begin
               acc_in = '0; q_in = gdelta; cnt_in = 7'd64; state_in = ST_MUL;
               func_in = FUNC_NONE;
            end
         end
         ST_GAP_END: begin
            if (hcnt_ff != '0 && !gapok) bad_in = 1'b1;
            hf_in = fr_ff; ht_in = nt_ff; hcnt_in = hnext;
            pt_in = '0; of_in = anc_f_ff; ot_in = anc_t_ff;
            if (!fullnow) st_in = STATUS_FAILED;
            else if (bad_in) begin
               st_in = STATUS_FAILED; hcnt_in = '0; bad_in = 1'b0;
            end else st_in = STATUS_MODIFY;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // gap multiply flows into the gap divide
      if (state_ff == ST_MUL && cnt_ff == 7'd1 && func_ff == FUNC_NONE)
         state_in = ST_GAP_DIV;
   end

endmodule
